### src/s1mh_pkg.sv
// Shared types, constants and helpers for the SHA-1 message hasher.
// Used by s1mh_rounds and sha1_message_hasher. No dependencies.
package s1mh_pkg;

  // Geometry of one message block
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned BlockWords = BlockBytes / 4;
  localparam int unsigned NumRounds  = 80;
  localparam int unsigned NumChain   = 5;
  localparam int unsigned LenOffset  = BlockBytes - 8;

  localparam logic [7:0] PadByte = 8'h80;

  // Round groups of twenty rounds each
  typedef enum logic [1:0] {
    GRP_CH   = 2'd0,
    GRP_PAR1 = 2'd1,
    GRP_MAJ  = 2'd2,
    GRP_PAR2 = 2'd3
  } s1mh_grp_e;

  // Controls from the sequencer to the round datapath
  typedef struct packed {
    logic      w_load;    // shift one message word into the schedule
    logic      h_shift;   // shift one word into the working registers
    logic      round_en;  // run one compression round
    s1mh_grp_e grp;       // round group of the current round
  } s1mh_ctl_t;

  // Initial chaining value, by word index
  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0:    w = 32'h67452301;
      3'd1:    w = 32'hEFCDAB89;
      3'd2:    w = 32'h98BADCFE;
      3'd3:    w = 32'h10325476;
      3'd4:    w = 32'hC3D2E1F0;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  // Round constant, by round group
  function automatic logic [31:0] round_k(input s1mh_grp_e grp);
    logic [31:0] k;
    case (grp)
      GRP_CH:   k = 32'h5A827999;
      GRP_PAR1: k = 32'h6ED9EBA1;
      GRP_MAJ:  k = 32'h8F1BBCDC;
      GRP_PAR2: k = 32'hCA62C1D6;
      default:  k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

### src/sha1_message_hasher.sv
// SHA-1 message hasher top level: sequencer, block and chaining memories, padding.
// Depends on s1mh_pkg and s1mh_rounds.
//
//   channel  | signals                                             | dir
//   ---------+-----------------------------------------------------+-----
//   in       | in_valid_i, in_stall_o, data_byte_i, byte_valid_i,  | in
//            | end_of_message_i                                    |
//   out      | out_valid_o, out_stall_i, digest_word_o,            | out
//            | word_index_o, ring_id_o, last_word_o                |
//   cfg      | cfg_we_i, cfg_wdata_i (id_bits)                     | in
//
// Message bytes are taken one per cycle while the input is not stalled. Every 64th byte
// starts a compression that stalls the input while it reads the block and chaining
// memories, runs 80 rounds on the single round unit, read-add-writes the chaining memory.
// A final request pushes 9 to 72 pad bytes, pauses once at offset 56, runs one or two
// compressions, then issues five digest words; output stall holds all but the fifth word.
// Reset marks the chaining memory as holding the initial value; no clearing pass.
module sha1_message_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic [31:0] ring_id_o,
  output logic        last_word_o
);
  import s1mh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD_ONE,
    S_PAD_ZERO,
    S_PAD_LEN,
    S_LOAD,
    S_ROUND,
    S_UPDATE,
    S_OUT
  } state_e;

  state_e      state_q, state_d, ret_q, ret_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] count_q, count_d;
  logic [63:0] len_q, len_d;
  logic [23:0] pack_q, pack_d;
  logic [5:0]  id_bits_q;
  logic        fresh_q, fresh_d;
  logic        blk_vld_q, chn_vld_q;
  logic [2:0]  chn_raddr_q;

  logic        out_valid_q, out_valid_d;
  logic [31:0] digest_q, digest_d;
  logic [2:0]  index_q, index_d;
  logic [31:0] ring_q, ring_d;
  logic        last_q, last_d;

  // Memories
  logic [31:0] blk_mem [BlockWords];
  logic [31:0] chn_mem [NumChain];
  logic [31:0] blk_rdata_q, chn_rdata_q;

  logic        blk_we, blk_re, chn_we, chn_re;
  logic [3:0]  blk_waddr, blk_raddr;
  logic [2:0]  chn_raddr;
  logic [31:0] blk_wdata, chn_wdata, chn_rd;

  // Byte push
  logic        push_en;
  logic [7:0]  push_byte;
  state_e      push_next;
  logic [5:0]  pos;

  s1mh_ctl_t   ctl;
  logic [31:0] h_din;
  logic [31:0] a_val;
  logic [31:0] ring_mask;

  assign pos    = count_q[5:0];
  assign chn_rd = fresh_q ? init_word(chn_raddr_q) : chn_rdata_q;

  // Ring identifier mask; zero bits gives zero, 32 or more keeps all
  assign ring_mask = (id_bits_q >= 6'd32) ? '1 : ((32'd1 << id_bits_q[4:0]) - 32'd1);

  s1mh_rounds u_rounds (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .w_din_i (blk_rdata_q),
    .h_din_i (h_din),
    .a_o     (a_val)
  );

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cnt_d       = cnt_q;
    count_d     = count_q;
    len_d       = len_q;
    pack_d      = pack_q;
    fresh_d     = fresh_q;
    out_valid_d = out_valid_q;
    digest_d    = digest_q;
    index_d     = index_q;
    ring_d      = ring_q;
    last_d      = last_q;
    push_en     = 1'b0;
    push_byte   = 8'h00;
    push_next   = state_q;
    blk_re      = 1'b0;
    blk_raddr   = cnt_q[3:0];
    chn_re      = 1'b0;
    chn_raddr   = cnt_q[2:0];
    chn_we      = 1'b0;
    chn_wdata   = chn_rd + a_val;
    h_din       = chn_rd;
    ctl         = '{w_load: 1'b0, h_shift: 1'b0, round_en: 1'b0, grp: GRP_CH};

    // Result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          len_d     = {count_q[60:0] + {60'd0, byte_valid_i}, 3'b000};
          push_next = end_of_message_i ? S_PAD_ONE : S_IDLE;
          if (byte_valid_i) begin
            push_en   = 1'b1;
            push_byte = data_byte_i;
          end else begin
            state_d = push_next;
          end
        end
      end
      S_PAD_ONE: begin
        push_en   = 1'b1;
        push_byte = PadByte;
        push_next = S_PAD_ZERO;
      end
      S_PAD_ZERO: begin
        if (pos == 6'(LenOffset)) begin
          state_d = S_PAD_LEN;
        end else begin
          push_en   = 1'b1;
          push_next = S_PAD_ZERO;
        end
      end
      S_PAD_LEN: begin
        push_en   = 1'b1;
        push_byte = len_q[63:56];
        len_d     = {len_q[55:0], 8'h00};
        push_next = (pos == 6'(BlockBytes - 1)) ? S_OUT : S_PAD_LEN;
      end
      S_LOAD: begin
        blk_re      = (cnt_q < 7'(BlockWords));
        chn_re      = (cnt_q < 7'(NumChain));
        ctl.w_load  = blk_vld_q;
        ctl.h_shift = chn_vld_q;
        if (cnt_q == 7'(BlockWords)) begin
          state_d = S_ROUND;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_ROUND: begin
        ctl.round_en = 1'b1;
        if (cnt_q < 7'd20) begin
          ctl.grp = GRP_CH;
        end else if (cnt_q < 7'd40) begin
          ctl.grp = GRP_PAR1;
        end else if (cnt_q < 7'd60) begin
          ctl.grp = GRP_MAJ;
        end else begin
          ctl.grp = GRP_PAR2;
        end
        if (cnt_q == 7'(NumRounds - 1)) begin
          state_d = S_UPDATE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_UPDATE: begin
        // Read chaining word, add working word, write back; rotate result in
        chn_re = (cnt_q < 7'(NumChain));
        if (chn_vld_q) begin
          chn_we      = 1'b1;
          ctl.h_shift = 1'b1;
          h_din       = chn_wdata;
        end
        if (cnt_q == 7'(NumChain)) begin
          state_d = ret_q;
          cnt_d   = '0;
          fresh_d = (ret_q == S_OUT);
          if (ret_q == S_OUT) begin
            count_d = '0;
          end
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          digest_d    = a_val;
          index_d     = cnt_q[2:0];
          last_d      = (cnt_q == 7'(NumChain - 1));
          ctl.h_shift = 1'b1;
          if (cnt_q == 7'd0) begin
            ring_d = a_val & ring_mask;
          end
          if (cnt_q == 7'(NumChain - 1)) begin
            state_d = S_IDLE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 7'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Byte push: pack into words, start compression on the last byte of a block
    if (push_en) begin
      count_d = count_q + 64'd1;
      if (pos[1:0] != 2'b11) begin
        pack_d = {pack_q[15:0], push_byte};
      end
      if (pos == 6'(BlockBytes - 1)) begin
        state_d = S_LOAD;
        ret_d   = push_next;
        cnt_d   = '0;
      end else begin
        state_d = push_next;
      end
    end
  end

  assign blk_we    = push_en && (pos[1:0] == 2'b11);
  assign blk_waddr = pos[5:2];
  assign blk_wdata = {pack_q, push_byte};

  // Block word memory
  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    if (blk_re) begin
      blk_rdata_q <= blk_mem[blk_raddr];
    end
  end

  // Chaining word memory
  always_ff @(posedge clk_i) begin
    if (chn_we) begin
      chn_mem[chn_raddr_q] <= chn_wdata;
    end
    if (chn_re) begin
      chn_rdata_q <= chn_mem[chn_raddr];
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      fresh_q     <= 1'b1;
      blk_vld_q   <= 1'b0;
      chn_vld_q   <= 1'b0;
      chn_raddr_q <= '0;
      id_bits_q   <= 6'd32;
      out_valid_q <= 1'b0;
      digest_q    <= '0;
      index_q     <= '0;
      ring_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      fresh_q     <= fresh_d;
      blk_vld_q   <= blk_re;
      chn_vld_q   <= chn_re;
      if (chn_re) begin
        chn_raddr_q <= chn_raddr;
      end
      if (cfg_we_i) begin
        id_bits_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
      digest_q    <= digest_d;
      index_q     <= index_d;
      ring_q      <= ring_d;
      last_q      <= last_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    pack_q   <= pack_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign digest_word_o = digest_q;
  assign word_index_o  = index_q;
  assign ring_id_o     = ring_q;
  assign last_word_o   = last_q;

endmodule

### src/s1mh_rounds.sv
// SHA-1 round datapath: working registers a..e and the 16-word schedule window.
// Depends on s1mh_pkg for the control struct and the round constants.
module s1mh_rounds (
  input  logic              clk_i,
  input  s1mh_pkg::s1mh_ctl_t ctl_i,
  input  logic [31:0]       w_din_i,
  input  logic [31:0]       h_din_i,
  output logic [31:0]       a_o
);
  import s1mh_pkg::*;

  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] w_q [BlockWords];
  logic [31:0] f_val;
  logic [31:0] w_new;
  logic [31:0] temp;

  // Boolean function of the round group
  always_comb begin
    case (ctl_i.grp)
      GRP_CH:   f_val = (b_q & c_q) | (~b_q & d_q);
      GRP_MAJ:  f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      default:  f_val = b_q ^ c_q ^ d_q;
    endcase
  end

  // Next schedule word: W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t])
  always_comb begin
    w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  assign temp = {a_q[26:0], a_q[31:27]} + f_val + e_q + round_k(ctl_i.grp) + w_q[0];

  // Schedule window: w_q[0] is the word of the current round
  always_ff @(posedge clk_i) begin
    if (ctl_i.round_en || ctl_i.w_load) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[BlockWords-1] <= ctl_i.round_en ? w_new : w_din_i;
    end
  end

  // Working registers: one round, or a shift that loads / rotates words
  always_ff @(posedge clk_i) begin
    if (ctl_i.round_en) begin
      a_q <= temp;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end else if (ctl_i.h_shift) begin
      a_q <= b_q;
      b_q <= c_q;
      c_q <= d_q;
      d_q <= e_q;
      e_q <= h_din_i;
    end
  end

  assign a_o = a_q;

endmodule
